/* rtl/sfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg: shared definitions for the serial frame receiver
// Buffer sizing, action, mode, register and error codes, parse phases.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int BUF_DEPTH = 256;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);
  localparam int CNT_NAT   = $clog2(BUF_DEPTH + 1);
  localparam int CNT_W     = (CNT_NAT > 9) ? CNT_NAT : 9;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [16:0] TICK_MAX = 17'h1FFFF;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [7:0] CH_ARROW  = 8'h3C;

  typedef enum logic [1:0] {
    ACT_BYTE    = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_READ    = 2'd2,
    ACT_RELEASE = 2'd3
  } sfr_action_e;

  typedef enum logic [1:0] {
    MODE_STOP    = 2'd0,
    MODE_MSP     = 2'd1,
    MODE_DISCARD = 2'd2,
    MODE_SPARE   = 2'd3
  } sfr_mode_e;

  typedef enum logic [1:0] {
    REG_MODE    = 2'd0,
    REG_STOP    = 2'd1,
    REG_LIMIT   = 2'd2,
    REG_TIMEOUT = 2'd3
  } sfr_reg_e;

  typedef enum logic [1:0] {
    FERR_NONE     = 2'd0,
    FERR_CHECKSUM = 2'd1,
    FERR_LENGTH   = 2'd2
  } sfr_ferr_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_DOLLAR  = 3'd1,
    PH_M       = 3'd2,
    PH_ARROW   = 3'd3,
    PH_LEN_HI  = 3'd4,
    PH_LEN_LO  = 3'd5,
    PH_PAYLOAD = 3'd6
  } sfr_phase_e;

  typedef struct packed {
    logic       byte_taken;
    logic       message_ready;
    logic [8:0] message_length;
    logic [7:0] command_code;
    logic       command_valid;
    logic       rd_sel;
    logic       timeout_cleared;
    logic       overflow_cleared;
    logic [1:0] frame_error;
  } sfr_res_t;

endpackage

/* rtl/sfr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_if: request channels of the serial frame receiver
// Input request, result and configuration write channels.
// ----------------------------------------------------------------------------
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, action, rx_byte, read_index, input ready);
  modport sink   (input valid, action, rx_byte, read_index, output ready);
endinterface

interface sfr_out_if;
  logic       valid;
  logic       ready;
  logic       byte_taken;
  logic       message_ready;
  logic [8:0] message_length;
  logic [7:0] command_code;
  logic       command_valid;
  logic [7:0] read_data;
  logic       timeout_cleared;
  logic       overflow_cleared;
  logic [1:0] frame_error;

  modport source (output valid, byte_taken, message_ready, message_length, command_code,
                  command_valid, read_data, timeout_cleared, overflow_cleared,
                  frame_error, input ready);
  modport sink   (input valid, byte_taken, message_ready, message_length, command_code,
                  command_valid, read_data, timeout_cleared, overflow_cleared,
                  frame_error, output ready);
endinterface

interface sfr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sfr_pkg::CFG_IDX_W-1:0] index;
  logic [sfr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/serial_frame_receiver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_receiver: MSP / stop-character message receiver
// Parses received bytes into a message buffer and answers buffer reads.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   requests: received byte, millisecond tick, buffer read or release.
//   out_o  one result per request, in request order.
//   cfg_i  register writes (mode, stop char, buffer limit, idle timeout),
//          always ready; write only while no request is in flight.
// Throughput: one request per cycle while out_o takes results. All parser
//   state sits in flops and is updated in the accept cycle; the message buffer
//   is a synchronous RAM with one write and one registered read port.
// Result path: each result passes the RAM read stage, then the output
//   register, before it shows on out_o.
// Stall: a held result waits in the output register while one more request
//   is taken into the RAM read stage; in_i.ready drops only when both hold.
// Reset: parser returns to idle, the buffer is empty, registers take their
//   defaults. Buffer contents are not cleared; unwritten entries read as
//   undefined.
// ----------------------------------------------------------------------------
module serial_frame_receiver (
  input  logic          clk_i,
  input  logic          rst_ni,
  sfr_in_if.sink        in_i,
  sfr_out_if.source     out_o,
  sfr_cfg_if.sink       cfg_i
);

  localparam int AW = sfr_pkg::BUF_AW;
  localparam int CW = sfr_pkg::CNT_W;

  logic [1:0]  mode_q;
  logic [7:0]  stop_q;
  logic [8:0]  limit_q;
  logic [15:0] timeout_q;

  logic [CW-1:0]        wi_q, wi_d;
  sfr_pkg::sfr_phase_e  ph_q, ph_d;
  logic [7:0]           lenh_q, lenh_d;
  logic [15:0]          plen_q, plen_d;
  logic [7:0]           xor_q, xor_d;
  logic [7:0]           cmd_q, cmd_d;
  logic                 seen_q, seen_d;
  logic                 hold_q, hold_d;
  logic [16:0]          idle_q, idle_d;

  logic [7:0]    mem [sfr_pkg::BUF_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [7:0]    mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic [7:0]    rdata_q;

  logic               s1_valid_q, out_valid_q;
  sfr_pkg::sfr_res_t  s1_q, res_d, out_q;
  logic [7:0]         out_rdata_q;
  logic               s1_adv, in_fire;

  logic [CW-1:0] usable;
  logic          taken, tclr, oclr, rd_ok;
  logic [1:0]    ferr;
  logic          st_en;
  logic [7:0]    st_val;

  assign s1_adv  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    if (limit_q == 9'd0) begin
      usable = CW'(1);
    end else if (CW'(limit_q) > CW'(sfr_pkg::BUF_DEPTH)) begin
      usable = CW'(sfr_pkg::BUF_DEPTH);
    end else begin
      usable = CW'(limit_q);
    end
  end

  always_comb begin
    wi_d   = wi_q;
    ph_d   = ph_q;
    lenh_d = lenh_q;
    plen_d = plen_q;
    xor_d  = xor_q;
    cmd_d  = cmd_q;
    seen_d = seen_q;
    hold_d = hold_q;
    idle_d = idle_q;
    taken  = 1'b0;
    tclr   = 1'b0;
    oclr   = 1'b0;
    ferr   = sfr_pkg::FERR_NONE;
    st_en  = 1'b0;
    st_val = 8'd0;
    mem_re = 1'b0;
    mem_ra = AW'(in_i.read_index);
    rd_ok  = 1'b0;
    if (in_fire) begin
      case (sfr_pkg::sfr_action_e'(in_i.action))
        sfr_pkg::ACT_BYTE: begin
          if (!hold_q) begin
            taken  = 1'b1;
            idle_d = 17'd0;
            if (wi_q >= usable) begin
              wi_d   = '0;
              seen_d = 1'b0;
              hold_d = 1'b0;
              ph_d   = sfr_pkg::PH_IDLE;
              oclr   = 1'b1;
            end
            if (mode_q == sfr_pkg::MODE_STOP) begin
              st_en = 1'b1;
              if (in_i.rx_byte == stop_q) begin
                st_val = 8'd0;
                hold_d = 1'b1;
              end else begin
                st_val = in_i.rx_byte;
              end
            end else if (mode_q == sfr_pkg::MODE_MSP) begin
              case (ph_d)
                sfr_pkg::PH_IDLE: begin
                  ph_d = (in_i.rx_byte == sfr_pkg::CH_DOLLAR) ? sfr_pkg::PH_DOLLAR
                                                              : sfr_pkg::PH_IDLE;
                end
                sfr_pkg::PH_DOLLAR: begin
                  ph_d = (in_i.rx_byte == sfr_pkg::CH_M) ? sfr_pkg::PH_M : sfr_pkg::PH_IDLE;
                end
                sfr_pkg::PH_M: begin
                  ph_d = (in_i.rx_byte == sfr_pkg::CH_ARROW) ? sfr_pkg::PH_ARROW
                                                             : sfr_pkg::PH_IDLE;
                end
                sfr_pkg::PH_ARROW: begin
                  lenh_d = in_i.rx_byte;
                  wi_d   = '0;
                  xor_d  = in_i.rx_byte;
                  ph_d   = sfr_pkg::PH_LEN_HI;
                end
                sfr_pkg::PH_LEN_HI: begin
                  plen_d = {lenh_q, in_i.rx_byte};
                  xor_d  = xor_q ^ in_i.rx_byte;
                  if ({lenh_q, in_i.rx_byte} >= 16'(usable)) begin
                    ph_d = sfr_pkg::PH_IDLE;
                    ferr = sfr_pkg::FERR_LENGTH;
                  end else begin
                    ph_d = sfr_pkg::PH_LEN_LO;
                  end
                end
                sfr_pkg::PH_LEN_LO: begin
                  cmd_d  = in_i.rx_byte;
                  seen_d = 1'b1;
                  xor_d  = xor_q ^ in_i.rx_byte;
                  ph_d   = sfr_pkg::PH_PAYLOAD;
                end
                sfr_pkg::PH_PAYLOAD: begin
                  if (16'(wi_d) < plen_q) begin
                    xor_d  = xor_q ^ in_i.rx_byte;
                    st_en  = 1'b1;
                    st_val = in_i.rx_byte;
                  end else begin
                    if (xor_q == in_i.rx_byte) begin
                      st_en  = 1'b1;
                      st_val = 8'd0;
                      hold_d = 1'b1;
                    end else begin
                      wi_d   = '0;
                      seen_d = 1'b0;
                      hold_d = 1'b0;
                      ferr   = sfr_pkg::FERR_CHECKSUM;
                    end
                    ph_d = sfr_pkg::PH_IDLE;
                  end
                end
                default: begin
                  ph_d = sfr_pkg::PH_IDLE;
                end
              endcase
            end
          end
        end
        sfr_pkg::ACT_TICK: begin
          if (idle_q < sfr_pkg::TICK_MAX) begin
            idle_d = idle_q + 17'd1;
          end
          if (!hold_q && (wi_q != '0) && (idle_d > {1'b0, timeout_q})) begin
            wi_d   = '0;
            seen_d = 1'b0;
            ph_d   = sfr_pkg::PH_IDLE;
            tclr   = 1'b1;
          end
        end
        sfr_pkg::ACT_READ: begin
          rd_ok  = 32'(in_i.read_index) < 32'(sfr_pkg::BUF_DEPTH);
          mem_re = rd_ok;
        end
        default: begin
          wi_d   = '0;
          seen_d = 1'b0;
          hold_d = 1'b0;
        end
      endcase
    end
    mem_we = 1'b0;
    mem_wa = wi_d[AW-1:0];
    mem_wd = st_val;
    if (st_en && (wi_d < CW'(sfr_pkg::BUF_DEPTH))) begin
      mem_we = 1'b1;
      wi_d   = wi_d + CW'(1);
    end
  end

  always_comb begin
    res_d.byte_taken       = taken;
    res_d.message_ready    = hold_d;
    res_d.message_length   = 9'(wi_d);
    res_d.command_code     = seen_d ? cmd_d : 8'd0;
    res_d.command_valid    = seen_d;
    res_d.rd_sel           = rd_ok;
    res_d.timeout_cleared  = tclr;
    res_d.overflow_cleared = oclr;
    res_d.frame_error      = ferr;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= sfr_pkg::MODE_MSP;
      stop_q    <= 8'd10;
      limit_q   <= 9'd256;
      timeout_q <= 16'd100;
    end else if (cfg_i.valid) begin
      case (sfr_pkg::sfr_reg_e'(cfg_i.index))
        sfr_pkg::REG_MODE:    mode_q    <= cfg_i.data[1:0];
        sfr_pkg::REG_STOP:    stop_q    <= cfg_i.data[7:0];
        sfr_pkg::REG_LIMIT:   limit_q   <= cfg_i.data[8:0];
        sfr_pkg::REG_TIMEOUT: timeout_q <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q   <= '0;
      ph_q   <= sfr_pkg::PH_IDLE;
      lenh_q <= 8'd0;
      plen_q <= 16'd0;
      xor_q  <= 8'd0;
      cmd_q  <= 8'd0;
      seen_q <= 1'b0;
      hold_q <= 1'b0;
      idle_q <= 17'd0;
    end else begin
      wi_q   <= wi_d;
      ph_q   <= ph_d;
      lenh_q <= lenh_d;
      plen_q <= plen_d;
      xor_q  <= xor_d;
      cmd_q  <= cmd_d;
      seen_q <= seen_d;
      hold_q <= hold_d;
      idle_q <= idle_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= res_d;
    end
    if (s1_adv) begin
      out_q       <= s1_q;
      out_rdata_q <= s1_q.rd_sel ? rdata_q : 8'd0;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.byte_taken       = out_q.byte_taken;
  assign out_o.message_ready    = out_q.message_ready;
  assign out_o.message_length   = out_q.message_length;
  assign out_o.command_code     = out_q.command_code;
  assign out_o.command_valid    = out_q.command_valid;
  assign out_o.read_data        = out_rdata_q;
  assign out_o.timeout_cleared  = out_q.timeout_cleared;
  assign out_o.overflow_cleared = out_q.overflow_cleared;
  assign out_o.frame_error      = out_q.frame_error;

endmodule
